>>> rtl/core/cfd_pkg.sv
// Shared types and constants for the checksum frame deframer.
// Status codes of the result stream and configuration register indexes.
// No dependencies.
package cfd_pkg;

	typedef logic [2:0] status_t;
	typedef logic [7:0] byte_t;

	localparam status_t ST_PAYLOAD  = 3'd0;
	localparam status_t ST_ACCEPT   = 3'd1;
	localparam status_t ST_MISMATCH = 3'd2;
	localparam status_t ST_EMPTY    = 3'd3;
	localparam status_t ST_OVERFLOW = 3'd4;

	localparam int CFG_IDX_W = 8;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START_BYTE = 8'd0;
	localparam cfg_idx_t CFG_END_BYTE   = 8'd1;

	localparam byte_t START_BYTE_RST = 8'd170;
	localparam byte_t END_BYTE_RST   = 8'd85;

endpackage

>>> rtl/core/cfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the bytes of the open frame. No dependencies.
module cfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/checksum_frame_deframer.sv
// Top level of the checksum frame deframer: framing, checksum check, replay.
// Depends on cfd_pkg and cfd_ram.
//
// Channel   | Dir | Signals                        | Contents (low bit up)
// ----------+-----+--------------------------------+------------------------------------
// s_axis    | in  | tvalid, tready, tdata[7:0]     | rx_byte
// m_axis    | out | tvalid, tready, tdata[23:0],   | data_byte, computed_sum,
//           |     | tuser[2:0], tlast              | received_sum; tuser = status
// cfg       | in  | cfg_valid, cfg_ready,          | cfg_index 0 start_byte,
//           |     | cfg_index[7:0], cfg_data[7:0]  | 1 end_byte, others ignored
//
// A byte that opens, extends or is ignored by a frame is taken in S_RX.
// A closing end byte takes its own transaction, then the check (S_CHK), then for
// each payload byte a RAM read (S_RD) and an output load (S_PAY), then the final
// status transaction (S_STAT); a mismatched frame skips the payload steps, and an empty
// or overflowed frame also skips the check, going straight to its status.
// The frame RAM port and the single shared 8-bit adder set this sequence.
// Reset is asynchronous; the frame RAM needs no clearing pass.
// A stalled output holds the sequencer in S_PAY or S_STAT, where s_axis_tready is low.
module checksum_frame_deframer #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// slave stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
	// master stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,   // [7:0] data_byte, [15:8] computed_sum,
	                                            // [23:16] received_sum
	output cfd_pkg::status_t    m_axis_tuser,   // [2:0] status
	output logic                m_axis_tlast,   // last
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfd_pkg::cfg_idx_t   cfg_index,
	input  logic [7:0]          cfg_data
);

	import cfd_pkg::*;

	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_RX   = 3'd0;  // take input bytes
	localparam logic [2:0] S_CHK  = 3'd1;  // subtract checksum byte, compare
	localparam logic [2:0] S_RD   = 3'd2;  // issue RAM read of next payload byte
	localparam logic [2:0] S_PAY  = 3'd3;  // push payload byte out
	localparam logic [2:0] S_STAT = 3'd4;  // push closing status result

	logic [2:0]        state_q;
	logic              in_frame_q;
	logic [CNT_W-1:0]  count_q;
	byte_t             sum_q;
	byte_t             last_q;
	byte_t             start_q;
	byte_t             end_q;
	status_t           pend_q;
	logic [ADDR_W-1:0] rd_idx_q;

	logic              out_valid_q;
	byte_t             out_data_q;
	status_t           out_stat_q;
	byte_t             out_csum_q;
	byte_t             out_rsum_q;
	logic              out_last_q;

	logic    rx_acc;
	logic    is_start;
	logic    is_end;
	logic    full;
	logic    ram_wr;
	logic    ram_rd;
	byte_t   ram_rd_data;
	byte_t   add_b;
	logic    add_cin;
	byte_t   add_y;
	logic    out_free;
	logic    out_load;
	logic    sums_valid;
	logic    last_pay;
	byte_t   out_data_d;
	status_t out_stat_d;
	byte_t   out_csum_d;
	byte_t   out_rsum_d;

	assign s_axis_tready = (state_q == S_RX);
	assign cfg_ready     = 1'b1;

	assign rx_acc   = s_axis_tvalid && s_axis_tready;
	assign is_start = (s_axis_tdata == start_q);
	assign is_end   = (s_axis_tdata == end_q);
	assign full     = (count_q == CNT_W'(BUFFER_DEPTH));
	assign ram_wr   = rx_acc && in_frame_q && !is_end && !full;
	assign ram_rd   = (state_q == S_RD);

	// Shared adder: accumulate on store, subtract the checksum byte on check.
	assign add_b   = (state_q == S_CHK) ? ~last_q : s_axis_tdata;
	assign add_cin = (state_q == S_CHK);
	assign add_y   = sum_q + add_b + 8'(add_cin);

	// Last payload byte when the index reaches payload length minus one.
	assign last_pay = ((CNT_W'(rd_idx_q) + CNT_W'(2)) == count_q);

	assign out_free   = !out_valid_q || m_axis_tready;
	assign out_load   = out_free && ((state_q == S_PAY) || (state_q == S_STAT));
	assign sums_valid = (state_q == S_STAT) && ((pend_q == ST_ACCEPT) || (pend_q == ST_MISMATCH));
	assign out_data_d = (state_q == S_PAY) ? ram_rd_data : 8'd0;
	assign out_stat_d = (state_q == S_PAY) ? ST_PAYLOAD : pend_q;
	assign out_csum_d = sums_valid ? sum_q : 8'd0;
	assign out_rsum_d = sums_valid ? last_q : 8'd0;

	cfd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (s_axis_tdata),
		.rd_en   (ram_rd),
		.rd_addr (rd_idx_q),
		.rd_data (ram_rd_data)
	);

	// Configuration registers; writes must arrive only while the block is idle (the block does not enforce this).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_BYTE_RST;
			end_q   <= END_BYTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START_BYTE: start_q <= cfg_data;
				CFG_END_BYTE:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_RX;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			sum_q      <= '0;
			last_q     <= '0;
			pend_q     <= ST_EMPTY;
			rd_idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_RX: begin
					if (rx_acc) begin
						if (!in_frame_q) begin
							// open a frame on the start byte, drop everything else
							if (is_start) begin
								in_frame_q <= 1'b1;
								count_q    <= '0;
								sum_q      <= '0;
							end
						end else if (!is_end) begin
							if (!full) begin
								count_q <= count_q + 1'b1;
								sum_q   <= add_y;
								last_q  <= s_axis_tdata;
							end else begin
								// frame runs past the buffer: drop it
								in_frame_q <= 1'b0;
								pend_q     <= ST_OVERFLOW;
								state_q    <= S_STAT;
							end
						end else begin
							in_frame_q <= 1'b0;
							if (count_q == '0) begin
								pend_q  <= ST_EMPTY;
								state_q <= S_STAT;
							end else begin
								state_q <= S_CHK;
							end
						end
					end
				end
				S_CHK: begin
					// sum_q now holds the sum of all held bytes, last_q the checksum byte
					sum_q <= add_y;
					if (add_y != last_q) begin
						pend_q  <= ST_MISMATCH;
						state_q <= S_STAT;
					end else if (count_q == CNT_W'(1)) begin
						pend_q  <= ST_ACCEPT;
						state_q <= S_STAT;
					end else begin
						rd_idx_q <= '0;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_PAY;
				end
				S_PAY: begin
					if (out_free) begin
						if (last_pay) begin
							pend_q  <= ST_ACCEPT;
							state_q <= S_STAT;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= S_RD;
						end
					end
				end
				S_STAT: begin
					if (out_free) begin
						count_q <= '0;
						sum_q   <= '0;
						state_q <= S_RX;
					end
				end
				default: begin
					state_q <= S_RX;
				end
			endcase
		end
	end

	// Output register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_stat_q <= out_stat_d;
			out_csum_q <= out_csum_d;
			out_rsum_q <= out_rsum_d;
			out_last_q <= (state_q == S_STAT);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_rsum_q, out_csum_q, out_data_q};
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// The fill count never passes the buffer depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUFFER_DEPTH))
		else $error("fill count beyond buffer depth");

	// A non-empty frame closed by the end byte goes to the checksum check.
	a_end_to_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && in_frame_q && is_end && (count_q != '0)) |=> (state_q == S_CHK))
		else $error("closing end byte did not start the check");

	// Payload replay runs only after the frame has closed.
	a_replay_closed: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RD) || (state_q == S_PAY)) |-> !in_frame_q)
		else $error("payload replay while a frame is open");

	// Payload transactions never carry last.
	a_payload_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_PAYLOAD)) |-> !m_axis_tlast)
		else $error("payload transaction marked last");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for checksum_frame_deframer: directed frames from a table,
// then random frames under several framing settings, checked against a frame tracker.
// Depends on cfd_pkg and the deframer RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cfd_pkg::*;

	localparam int FRAME_DEPTH  = 64;
	localparam int PHASE_BYTES  = 40;     // frame bytes per random phase
	localparam int DRAIN_CYCLES = 5000;   // longest wait for the result stream to empty
	localparam int TAIL_CYCLES  = 8;      // lets a byte with no result finish after the results drain

	// One result transaction, fields from data_byte down to last
	typedef struct packed {
		byte_t   data_byte;
		status_t status;
		byte_t   computed_sum;
		byte_t   received_sum;
		logic    last;
	} frame_result_t;

	// Directed row: a received byte, and optionally the one status result it must give
	typedef struct packed {
		byte_t   rx;
		logic    pinned;
		status_t pin_status;
		byte_t   pin_csum;
		byte_t   pin_rsum;
	} directed_row_t;

	typedef enum {FR_GOOD, FR_BAD_SUM, FR_EMPTY, FR_OVERFLOW, FR_JUNK} frame_kind_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      s_axis_tvalid = 1'b0;
	logic      s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic      m_axis_tvalid;
	logic      m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // [7:0] data_byte, [15:8] computed_sum,
	                                    // [23:16] received_sum
	status_t   m_axis_tuser;            // [2:0] status
	logic      m_axis_tlast;            // last
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = '0;
	logic [7:0] cfg_data = 8'h00;

	checksum_frame_deframer #(
		.BUFFER_DEPTH(FRAME_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tracker copy of the block: framing bytes, open-frame flag, held bytes and their sum
	byte_t start_code = START_BYTE_RST;
	byte_t end_code   = END_BYTE_RST;
	bit    framing_open = 1'b0;
	int    held_count = 0;
	byte_t held_sum = 8'h00;
	byte_t held_bytes [FRAME_DEPTH];

	frame_result_t fresh_results [$];     // results of the byte just tracked
	frame_result_t awaited_results [$];   // results still owed by the block, oldest first

	bit run_failed = 1'b0;
	int gap_odds = 4;     // sender idles before one byte in gap_odds (0: never)
	int stall_odds = 8;   // receiver starts a stall on one cycle in stall_odds (0: never)
	int stall_left = 0;

	// Advance the tracker by one received byte and collect what it gives in fresh_results.
	function automatic void track_rx(byte_t b);
		int    plen;
		byte_t rsum;
		byte_t csum;
		fresh_results.delete();
		if (!framing_open) begin
			// Idle: only the start byte matters, and it is dropped
			if (b == start_code) begin
				framing_open = 1'b1;
				held_count = 0;
				held_sum = 8'h00;
			end
			return;
		end
		if (b != end_code) begin
			if (held_count < FRAME_DEPTH) begin
				held_bytes[held_count] = b;
				held_count++;
				held_sum = held_sum + b;
				return;
			end
			// One byte past a full buffer: drop the frame
			framing_open = 1'b0;
			held_count = 0;
			held_sum = 8'h00;
			fresh_results.push_back(frame_result_t'{8'h00, ST_OVERFLOW, 8'h00, 8'h00, 1'b1});
			return;
		end
		framing_open = 1'b0;
		if (held_count == 0) begin
			fresh_results.push_back(frame_result_t'{8'h00, ST_EMPTY, 8'h00, 8'h00, 1'b1});
		end else begin
			// The last held byte is the checksum; the rest is payload
			plen = held_count - 1;
			rsum = held_bytes[plen];
			csum = held_sum - rsum;
			if (csum != rsum) begin
				fresh_results.push_back(frame_result_t'{8'h00, ST_MISMATCH, csum, rsum, 1'b1});
			end else begin
				for (int i = 0; i < plen; i++)
					fresh_results.push_back(frame_result_t'{held_bytes[i], ST_PAYLOAD,
						8'h00, 8'h00, 1'b0});
				fresh_results.push_back(frame_result_t'{8'h00, ST_ACCEPT, csum, rsum, 1'b1});
			end
		end
		held_count = 0;
		held_sum = 8'h00;
	endfunction

	// Send one byte: maybe idle a burst first, then hold valid until the transaction.
	// A pinned byte owes exactly the given result instead of the tracker's.
	task automatic push_rx(byte_t b, bit pinned = 1'b0, frame_result_t pin = '0);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		track_rx(b);
		if (pinned)
			awaited_results.push_back(pin);
		else
			foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
	endtask

	// Drop valid, wait for every owed result, then let a byte with no result finish.
	task automatic settle();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			run_failed = 1'b1;
			awaited_results.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Hold one register write until its transaction; the caller lowers valid.
	task automatic cfg_write(cfg_idx_t idx, byte_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_START_BYTE)
			start_code = val;
		else if (idx == CFG_END_BYTE)
			end_code = val;
	endtask

	// Load both framing bytes, plus a write to an unused index that must change nothing.
	task automatic set_framing(byte_t s, byte_t e);
		cfg_write(CFG_START_BYTE, s);
		cfg_write(CFG_END_BYTE, e);
		cfg_write(cfg_idx_t'($urandom_range(2, 255)), 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Random byte that cannot close the frame early
	function automatic byte_t body_byte();
		byte_t b;
		do b = 8'($urandom); while (b == end_code);
		return b;
	endfunction

	// One frame with random content, led by a little noise; bytes_used skips the noise.
	task automatic send_frame(frame_kind_t kind, output int bytes_used);
		int    plen;
		int    r;
		byte_t b;
		byte_t sum;
		sum = 8'h00;
		r = $urandom_range(0, 19);
		plen = (r == 0) ? FRAME_DEPTH - 1 :
		       (r < 3)  ? $urandom_range(7, FRAME_DEPTH - 2) : $urandom_range(0, 6);
		// Idle noise never opens the frame, so the frame below stays well formed
		repeat ($urandom_range(0, 2)) begin
			do b = 8'($urandom); while (b == start_code);
			push_rx(b);
		end
		push_rx(start_code);
		bytes_used = 1;
		case (kind)
			FR_EMPTY: begin
			end
			FR_OVERFLOW: begin
				repeat (FRAME_DEPTH + 1) push_rx(body_byte());
				bytes_used += FRAME_DEPTH + 1;
			end
			FR_JUNK: begin
				repeat (plen) push_rx(8'($urandom));
				bytes_used += plen;
			end
			default: begin
				repeat (plen) begin
					b = body_byte();
					sum = sum + b;
					push_rx(b);
				end
				if (kind == FR_BAD_SUM)
					sum = sum + 8'($urandom_range(1, 255));
				push_rx(sum);
				bytes_used += plen + 1;
			end
		endcase
		// An overflowed frame is already closed by the block
		if (kind != FR_OVERFLOW) begin
			push_rx(end_code);
			bytes_used++;
		end
	endtask

	// Random frames, mostly good ones, until the phase has sent its share of bytes
	task automatic random_phase(bit with_overflow);
		int          sent;
		int          n;
		int          r;
		frame_kind_t kind;
		sent = 0;
		if (with_overflow) begin
			send_frame(FR_OVERFLOW, n);
			sent += n;
		end
		while (sent < PHASE_BYTES) begin
			r = $urandom_range(0, 39);
			kind = (r == 0) ? FR_OVERFLOW :
			       (r < 3)  ? FR_EMPTY :
			       (r < 7)  ? FR_BAD_SUM :
			       (r < 9)  ? FR_JUNK : FR_GOOD;
			send_frame(kind, n);
			sent += n;
		end
	endtask

	directed_row_t directed_rows [25] = '{
		'{8'h00, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // idle, not a start byte: ignored
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // reset start byte opens
		'{8'h55, 1'b1, ST_EMPTY,    8'h00, 8'h00},   // closed with nothing held
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h07, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // checksum byte alone
		'{8'h55, 1'b1, ST_MISMATCH, 8'h00, 8'h07},   // empty payload sums to zero
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h00, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // zero checksum alone
		'{8'h55, 1'b1, ST_ACCEPT,   8'h00, 8'h00},   // accepted, no payload
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // start byte inside a frame is data
		'{8'h01, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // sum wraps to 0xAA
		'{8'h55, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h80, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h7F, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h55, 1'b1, ST_MISMATCH, 8'h80, 8'h7F},
		'{8'hFF, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},   // idle, all ones: ignored
		'{8'hAA, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h00, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_PAYLOAD,  8'h00, 8'h00},
		'{8'h55, 1'b0, ST_PAYLOAD,  8'h00, 8'h00}
	};

	// Result receiver: stall in bursts of random length, or stay ready when stall_odds is 0
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left = $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			run_failed = 1'b1;
		end
	endtask

	frame_result_t observed;
	frame_result_t expected_head;

	// Compare every result transaction with the oldest owed result
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			observed = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8],
				m_axis_tdata[23:16], m_axis_tlast};
			if (awaited_results.size() == 0) begin
				$error("result with none owed: status %0d, data %0h, last %0b",
					observed.status, observed.data_byte, observed.last);
				run_failed = 1'b1;
			end else begin
				expected_head = awaited_results.pop_front();
				check_field("data_byte", expected_head.data_byte, observed.data_byte);
				check_field("status", expected_head.status, observed.status);
				check_field("computed_sum", expected_head.computed_sum, observed.computed_sum);
				check_field("received_sum", expected_head.received_sum, observed.received_sum);
				check_field("last", expected_head.last, observed.last);
			end
		end
	end

	initial begin
		frame_result_t pin;
		byte_t         v;
		byte_t         w;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset framing bytes
		foreach (directed_rows[i]) begin
			pin = '{8'h00, directed_rows[i].pin_status, directed_rows[i].pin_csum,
				directed_rows[i].pin_rsum, 1'b1};
			push_rx(directed_rows[i].rx, directed_rows[i].pinned, pin);
		end
		settle();

		// Extreme framing bytes, first one way round, then the other with heavy stalls
		set_framing(8'h00, 8'hFF);
		random_phase(1'b1);
		settle();

		gap_odds = 3;
		stall_odds = 3;
		set_framing(8'hFF, 8'h00);
		random_phase(1'b0);
		settle();

		// Start and end equal: the byte opens when idle and closes when in a frame
		gap_odds = 0;
		stall_odds = 12;
		v = 8'($urandom);
		set_framing(v, v);
		random_phase(1'b0);
		settle();

		// Last stretch at full rate, no idling on either side
		stall_odds = 0;
		v = 8'($urandom);
		do w = 8'($urandom); while (w == v);
		set_framing(v, w);
		random_phase(1'b1);
		settle();

		if (!run_failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Hard stop far beyond the slowest correct run
	initial begin
		#(20_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/cfd_pkg.sv
rtl/core/cfd_ram.sv
rtl/core/checksum_frame_deframer.sv
dv/testbench.sv
